// ----- src/urrm_pkg.sv -----
// Shared types and constants of the uniform range random mapper.
package urrm_pkg;

   localparam int DataW   = 31;
   localparam int CntW    = 6;
   localparam int DivCntW = 5;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;

   localparam logic [DataW-1:0] MaxRaw = 31'h7FFF_FFFF;
   localparam logic [DataW-1:0] MinBase = 31'd2;
   localparam logic [DivCntW-1:0] DivLastStep = 5'(DataW - 1);

   localparam logic [DataW-1:0] RangeLimitReset = 31'd100;
   localparam logic [DataW-1:0] DigitBaseReset  = 31'h7FFF_FFFF;

   localparam logic RegRangeLimit = 1'b0;
   localparam logic RegDigitBase  = 1'b1;

   typedef struct packed {
      logic             start;
      logic [DataW-1:0] dividend;
      logic [DataW-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [DataW-1:0] quotient;
      logic [DataW-1:0] remainder;
   } div_res_type;

endpackage

// ----- src/urrm_if.sv -----
// Valid/ready channel interfaces for raw words and mapped values.
interface urrm_req_if;
   logic                       valid;
   logic                       ready;
   logic [urrm_pkg::DataW-1:0] raw_word;

   modport source (output valid, output raw_word, input ready);
   modport sink (input valid, input raw_word, output ready);
endinterface

interface urrm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [urrm_pkg::DataW-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// ----- src/urrm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module urrm_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/urrm_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module urrm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  urrm_pkg::div_cmd_type cmd,
   output urrm_pkg::div_res_type res
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [urrm_pkg::DivCntW-1:0] step_ff, step_in;
   logic [urrm_pkg::DataW-1:0]   quo_ff, quo_in;
   logic [urrm_pkg::DataW-1:0]   rem_ff, rem_in;
   logic [urrm_pkg::DataW-1:0]   dvs_ff, dvs_in;
   logic [urrm_pkg::DataW:0]     rem_sh;
   logic [urrm_pkg::DataW:0]     rem_sub;
   logic                         fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[urrm_pkg::DataW-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[urrm_pkg::DataW-2:0], fits};
         rem_in  = fits ? rem_sub[urrm_pkg::DataW-1:0] : rem_sh[urrm_pkg::DataW-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == urrm_pkg::DivLastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign res.done      = done_ff;
   assign res.quotient  = quo_ff;
   assign res.remainder = rem_ff;

endmodule

// ----- src/uniform_range_random_mapper.sv -----
// Top level of the uniform range random mapper.
//
//   channel   direction  handshake      payload
//   req_bus   in         valid/ready    raw_word  (31 bit)
//   rsp_bus   out        valid/ready    value     (31 bit)
//   csr_*     in         APB write/read range_limit @0x0, digit_base @0x4
//
// Each raw word passes through the shared bit-serial divider and then updates the
// digit walk; a word that completes a value also loads the output register.
// After reset and after every register write the divider derives the bucket
// size and the digits of range_limit-1, one division per digit, during
// which req_bus.ready stays low. A waiting result does not block the next
// beat; a second result waits until the output register is free.
module uniform_range_random_mapper #(
   parameter int MAX_DIGITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   urrm_req_if.sink                      req_bus,
   urrm_rsp_if.source                    rsp_bus,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [urrm_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [urrm_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [urrm_pkg::CsrDataW-1:0] csr_prdata,
   output logic                          csr_pready
);

   localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam logic [urrm_pkg::CntW-1:0] DigMax = urrm_pkg::CntW'(MAX_DIGITS);

   typedef enum logic [2:0] {
      S_BKT_GO,
      S_BKT_WAIT,
      S_DIG_GO,
      S_DIG_WAIT,
      S_IDLE,
      S_ITEM_WAIT,
      S_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   logic [urrm_pkg::DataW-1:0]   range_limit_ff, range_limit_in;
   logic [urrm_pkg::DataW-1:0]   digit_base_ff, digit_base_in;
   logic [urrm_pkg::DataW-1:0]   base_ff, base_in;
   logic [urrm_pkg::DataW-1:0]   bmax_ff, bmax_in;
   logic [urrm_pkg::DataW-1:0]   bucket_ff, bucket_in;
   logic [urrm_pkg::DataW-1:0]   top_ff, top_in;
   logic [urrm_pkg::CntW-1:0]    dcnt_ff, dcnt_in;
   logic [urrm_pkg::CntW-1:0]    count_ff, count_in;
   logic                         sat_ff, sat_in;
   logic [urrm_pkg::CntW-1:0]    pos_ff, pos_in;
   logic                         tight_ff, tight_in;
   logic [urrm_pkg::DataW-1:0]   partial_ff, partial_in;
   logic [urrm_pkg::DataW-1:0]   prod_ff, prod_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [urrm_pkg::DataW-1:0]   rsp_value_ff, rsp_value_in;

   logic                         csr_wr;
   logic                         req_accept;
   logic [urrm_pkg::DataW-1:0]   eff_base;
   logic [urrm_pkg::DataW-1:0]   mul_low;
   logic [urrm_pkg::DataW-1:0]   digit;
   logic [urrm_pkg::DataW-1:0]   bound;
   logic [urrm_pkg::CntW-1:0]    pos_next;
   logic [urrm_pkg::CntW-1:0]    dcnt_next;
   logic [urrm_pkg::CntW-1:0]    rd_idx;
   logic                         ram_we;
   logic [urrm_pkg::DataW-1:0]   ram_rdata;
   urrm_pkg::div_cmd_type        div_cmd;
   urrm_pkg::div_res_type        div_res;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == urrm_pkg::RegDigitBase) ?
                       {1'b0, digit_base_ff} : {1'b0, range_limit_ff};

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_accept    = req_bus.valid & req_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.value = rsp_value_ff;

   assign eff_base = (digit_base_ff > urrm_pkg::MaxRaw) ? urrm_pkg::MaxRaw :
                     (digit_base_ff < urrm_pkg::MinBase) ? urrm_pkg::MinBase : digit_base_ff;
   assign mul_low   = partial_ff * base_ff;
   assign digit     = div_res.quotient;
   assign bound     = sat_ff ? bmax_ff : ram_rdata;
   assign pos_next  = pos_ff + 1'b1;
   assign dcnt_next = dcnt_ff + 1'b1;
   assign rd_idx    = count_ff - 1'b1 - pos_ff;
   assign ram_we    = (state_ff == S_DIG_WAIT) && div_res.done && (dcnt_ff < DigMax);

   always_comb begin
      div_cmd.start    = 1'b0;
      div_cmd.dividend = req_bus.raw_word;
      div_cmd.divisor  = bucket_ff;
      case (state_ff)
         S_BKT_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = urrm_pkg::MaxRaw;
            div_cmd.divisor  = eff_base;
         end
         S_DIG_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = top_ff;
            div_cmd.divisor  = base_ff;
         end
         S_IDLE: begin
            div_cmd.start = req_accept;
         end
         default: begin
            div_cmd.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      range_limit_in = range_limit_ff;
      digit_base_in  = digit_base_ff;
      base_in        = base_ff;
      bmax_in        = bmax_ff;
      bucket_in      = bucket_ff;
      top_in         = top_ff;
      dcnt_in        = dcnt_ff;
      count_in       = count_ff;
      sat_in         = sat_ff;
      pos_in         = pos_ff;
      tight_in       = tight_ff;
      partial_in     = partial_ff;
      prod_in        = mul_low;
      rsp_valid_in   = rsp_valid_ff & ~rsp_bus.ready;
      rsp_value_in   = rsp_value_ff;

      case (state_ff)
         S_BKT_GO: begin
            base_in  = eff_base;
            bmax_in  = eff_base - 1'b1;
            state_in = S_BKT_WAIT;
         end
         S_BKT_WAIT: begin
            if (div_res.done) begin
               bucket_in = (div_res.quotient == '0) ? urrm_pkg::DataW'(1) : div_res.quotient;
               top_in    = (range_limit_ff == '0) ? '0 : range_limit_ff - 1'b1;
               dcnt_in   = '0;
               state_in  = S_DIG_GO;
            end
         end
         S_DIG_GO: begin
            state_in = S_DIG_WAIT;
         end
         S_DIG_WAIT: begin
            if (div_res.done) begin
               dcnt_in = dcnt_next;
               top_in  = div_res.quotient;
               if (div_res.quotient == '0) begin
                  sat_in   = dcnt_next > DigMax;
                  count_in = (dcnt_next > DigMax) ? DigMax : dcnt_next;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_DIG_GO;
               end
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_ITEM_WAIT;
            end
         end
         S_ITEM_WAIT: begin
            if (div_res.done) begin
               state_in = S_IDLE;
               if (digit >= base_ff) begin
                  state_in = S_IDLE;
               end else if (pos_ff >= count_ff || (tight_ff && digit > bound)) begin
                  pos_in     = '0;
                  tight_in   = 1'b1;
                  partial_in = '0;
               end else begin
                  tight_in   = tight_ff && (digit == bound);
                  partial_in = prod_ff + digit;
                  pos_in     = pos_next;
                  if (pos_next >= count_ff) begin
                     state_in = S_EMIT;
                  end
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = partial_ff;
               pos_in       = '0;
               tight_in     = 1'b1;
               partial_in   = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_BKT_GO;
         end
      endcase

      if (csr_wr) begin
         if (csr_paddr[2] == urrm_pkg::RegDigitBase) begin
            digit_base_in = csr_pwdata[urrm_pkg::DataW-1:0];
         end else begin
            range_limit_in = csr_pwdata[urrm_pkg::DataW-1:0];
         end
         pos_in     = '0;
         tight_in   = 1'b1;
         partial_in = '0;
         state_in   = S_BKT_GO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_BKT_GO;
         range_limit_ff <= urrm_pkg::RangeLimitReset;
         digit_base_ff  <= urrm_pkg::DigitBaseReset;
         pos_ff         <= '0;
         tight_ff       <= 1'b1;
         partial_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         range_limit_ff <= range_limit_in;
         digit_base_ff  <= digit_base_in;
         pos_ff         <= pos_in;
         tight_ff       <= tight_in;
         partial_ff     <= partial_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      base_ff      <= base_in;
      bmax_ff      <= bmax_in;
      bucket_ff    <= bucket_in;
      top_ff       <= top_in;
      dcnt_ff      <= dcnt_in;
      count_ff     <= count_in;
      sat_ff       <= sat_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
   end

   urrm_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   urrm_ram #(
      .WIDTH (urrm_pkg::DataW),
      .DEPTH (MAX_DIGITS)
   ) u_bound_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (dcnt_ff[AW-1:0]),
      .wdata (div_res.remainder),
      .raddr (rd_idx[AW-1:0]),
      .rdata (ram_rdata)
   );

endmodule

// ----- src/urrm_checker.sv -----
// Port-level assertions of the uniform range random mapper and their binding.
module urrm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [urrm_pkg::DataW-1:0]    rsp_value,
   input logic                          csr_psel,
   input logic                          csr_penable,
   input logic                          csr_pwrite,
   input logic                          csr_pready
);

   logic csr_wr;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("result beat dropped or changed while stalled");

   a_cfg_busy: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> !req_ready)
      else $error("input taken right after a register write");

   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while a word is being divided");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a word in progress");

endmodule

bind uniform_range_random_mapper urrm_checker u_urrm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_value   (rsp_bus.value),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_pready  (csr_pready)
);
